// ----- rtl/core/qau_pkg.sv -----
// Shared types, constants and helper functions of the quaternion arithmetic unit.
package qau_pkg;

   localparam int FracBitsDef = 16;
   localparam int IterDef     = 24;
   localparam int DataW       = 32;
   localparam int AngW        = 26;

   // CORDIC start value (Q4.30) that cancels the rotation gain.
   localparam logic signed [33:0] CordicGain = 34'sd652032874;
   // pi / 360 in Q30: turns an angle in degrees into its half angle in radians.
   localparam logic signed [24:0] PiOver360Q30 = 25'sd9370165;

   localparam logic [31:0] AtanTab [0:31] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_NORM = 2'd1,
      OP_AXIS = 2'd2,
      OP_MAT  = 2'd3
   } op_type;

   // One accepted input word, unpacked.
   typedef struct packed {
      op_type            op;
      logic [3:0][31:0]  a;    // w, x, y, z
      logic [3:0][31:0]  b;    // w, x, y, z
      logic [AngW-1:0]   ang;
   } req_type;

   // Work record that travels down the pipeline.
   typedef struct packed {
      logic                   vld;
      op_type                 op;
      logic [2:0]             rerr;
      logic [3:0][31:0]       a;
      logic [2:0][3:0][31:0]  rv;
      logic [63:0]            sv;    // square root: remaining value
      logic [63:0]            sr;    // square root: partial root
      logic [3:0][33:0]       rem;   // divider remainders
      logic [3:0][31:0]       quo;   // divider quotients
      logic signed [33:0]     cx;
      logic signed [33:0]     cy;
      logic signed [33:0]     cz;
      logic                   cneg;
   } pipe_type;

   typedef struct packed {
      logic        ovf;
      logic [31:0] val;
   } sat_type;

   function automatic sat_type sat32(input logic signed [67:0] v);
      sat_type s;
      if (v > 68'sd2147483647) begin
         s.ovf = 1'b1;
         s.val = 32'h7FFF_FFFF;
      end else if (v < -68'sd2147483648) begin
         s.ovf = 1'b1;
         s.val = 32'h8000_0000;
      end else begin
         s.ovf = 1'b0;
         s.val = v[31:0];
      end
      return s;
   endfunction

   // Number of compare-subtract steps that take any 26-bit angle below one period.
   function automatic int mod_steps(input int f);
      longint p;
      int     n;
      p = longint'(720) << f;
      n = 0;
      while ((p << n) <= (longint'(1) << 25)) n++;
      return n;
   endfunction

endpackage

// ----- rtl/core/qau_front.sv -----
// Front pipeline stages: operand products, sums and saturation, angle folding.
module qau_front #(
   parameter int FRAC_BITS = qau_pkg::FracBitsDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              req_valid,
   input  qau_pkg::req_type  req_in,
   output logic              in_ready,
   output logic              a_vld,
   output qau_pkg::pipe_type q_out
);
   import qau_pkg::*;

   localparam int     ModSteps = mod_steps(FRAC_BITS);
   localparam longint Period   = longint'(720) << FRAC_BITS;
   localparam logic signed [41:0] Per     = 42'(longint'(720) << FRAC_BITS);
   localparam logic signed [41:0] HalfP   = 42'(longint'(360) << FRAC_BITS);
   localparam logic signed [41:0] Quarter = 42'(longint'(180) << FRAC_BITS);
   localparam logic signed [67:0] OneW    = 68'(longint'(1) << FRAC_BITS);

   typedef struct packed {
      logic               vld;
      op_type             op;
      logic [3:0][31:0]   a;
      logic [15:0][63:0]  p;
      logic signed [26:0] ang;
   } sta_type;

   sta_type  a_ff, a_in;
   pipe_type b_ff, b_in, c_ff, c_in;

   logic [15:0][31:0] ml, mr;
   logic [25:0]       aa;
   logic              ld_a;

   assign ld_a     = en || !a_ff.vld;
   assign in_ready = ld_a;
   assign a_vld    = a_ff.vld;

   // Stage A: sixteen products, operands picked by operation; angle brought below one period.
   always_comb begin
      ml = '0;
      mr = '0;
      unique case (req_in.op)
         OP_MUL: begin
            {ml[0],  mr[0]}  = {req_in.a[0], req_in.b[0]};
            {ml[1],  mr[1]}  = {req_in.a[1], req_in.b[1]};
            {ml[2],  mr[2]}  = {req_in.a[2], req_in.b[2]};
            {ml[3],  mr[3]}  = {req_in.a[3], req_in.b[3]};
            {ml[4],  mr[4]}  = {req_in.a[0], req_in.b[1]};
            {ml[5],  mr[5]}  = {req_in.a[1], req_in.b[0]};
            {ml[6],  mr[6]}  = {req_in.a[2], req_in.b[3]};
            {ml[7],  mr[7]}  = {req_in.a[3], req_in.b[2]};
            {ml[8],  mr[8]}  = {req_in.a[0], req_in.b[2]};
            {ml[9],  mr[9]}  = {req_in.a[2], req_in.b[0]};
            {ml[10], mr[10]} = {req_in.a[3], req_in.b[1]};
            {ml[11], mr[11]} = {req_in.a[1], req_in.b[3]};
            {ml[12], mr[12]} = {req_in.a[0], req_in.b[3]};
            {ml[13], mr[13]} = {req_in.a[3], req_in.b[0]};
            {ml[14], mr[14]} = {req_in.a[1], req_in.b[2]};
            {ml[15], mr[15]} = {req_in.a[2], req_in.b[1]};
         end
         OP_NORM: begin
            {ml[0], mr[0]} = {req_in.a[0], req_in.a[0]};
            {ml[1], mr[1]} = {req_in.a[1], req_in.a[1]};
            {ml[2], mr[2]} = {req_in.a[2], req_in.a[2]};
            {ml[3], mr[3]} = {req_in.a[3], req_in.a[3]};
         end
         OP_MAT: begin
            {ml[0], mr[0]} = {req_in.a[1], req_in.a[1]};
            {ml[1], mr[1]} = {req_in.a[2], req_in.a[2]};
            {ml[2], mr[2]} = {req_in.a[3], req_in.a[3]};
            {ml[3], mr[3]} = {req_in.a[1], req_in.a[2]};
            {ml[4], mr[4]} = {req_in.a[1], req_in.a[3]};
            {ml[5], mr[5]} = {req_in.a[2], req_in.a[3]};
            {ml[6], mr[6]} = {req_in.a[0], req_in.a[1]};
            {ml[7], mr[7]} = {req_in.a[0], req_in.a[2]};
            {ml[8], mr[8]} = {req_in.a[0], req_in.a[3]};
         end
         OP_AXIS: begin
            ml = '0;
         end
         default: begin
            ml = '0;
         end
      endcase
   end

   always_comb begin
      a_in.vld = req_valid;
      a_in.op  = req_in.op;
      a_in.a   = req_in.a;
      for (int k = 0; k < 16; k++) begin
         a_in.p[k] = 64'($signed(ml[k]) * $signed(mr[k]));
      end
      aa = req_in.ang[AngW-1] ? 26'(-$signed(req_in.ang)) : req_in.ang;
      for (int j = ModSteps - 1; j >= 0; j--) begin
         if (longint'(aa) >= (Period << j)) aa = aa - 26'(Period << j);
      end
      a_in.ang = req_in.ang[AngW-1] ? -$signed({1'b0, aa}) : $signed({1'b0, aa});
   end

   // Stage B: floor-shifted sums and saturation, sum of squares, angle folding.
   logic signed [63:0] t [16];
   logic signed [67:0] v [3][4];
   logic [65:0]        ss;
   logic signed [41:0] g;
   sat_type            s;

   always_comb begin
      b_in      = '0;
      b_in.vld  = a_ff.vld;
      b_in.op   = a_ff.op;
      b_in.a    = a_ff.a;
      ss        = '0;
      g         = '0;
      for (int k = 0; k < 16; k++) t[k] = $signed(a_ff.p[k]) >>> FRAC_BITS;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) v[r][c] = '0;
      end
      case (a_ff.op)
         OP_MUL: begin
            v[0][0] = 68'(t[0]) - 68'(t[1]) - 68'(t[2]) - 68'(t[3]);
            v[0][1] = 68'(t[4]) + 68'(t[5]) + 68'(t[6]) - 68'(t[7]);
            v[0][2] = 68'(t[8]) + 68'(t[9]) + 68'(t[10]) - 68'(t[11]);
            v[0][3] = 68'(t[12]) + 68'(t[13]) + 68'(t[14]) - 68'(t[15]);
         end
         OP_MAT: begin
            // Products: xx yy zz xy xz yz wx wy wz.
            v[0][0] = OneW - ((68'(t[1]) + 68'(t[2])) <<< 1);
            v[0][1] = (68'(t[3]) + 68'(t[8])) <<< 1;
            v[0][2] = (68'(t[4]) - 68'(t[7])) <<< 1;
            v[1][0] = (68'(t[3]) - 68'(t[8])) <<< 1;
            v[1][1] = OneW - ((68'(t[0]) + 68'(t[2])) <<< 1);
            v[1][2] = (68'(t[5]) + 68'(t[6])) <<< 1;
            v[2][0] = (68'(t[4]) + 68'(t[7])) <<< 1;
            v[2][1] = (68'(t[5]) - 68'(t[6])) <<< 1;
            v[2][2] = OneW - ((68'(t[0]) + 68'(t[1])) <<< 1);
         end
         OP_NORM: begin
            ss = 66'(a_ff.p[0]) + 66'(a_ff.p[1]) + 66'(a_ff.p[2]) + 66'(a_ff.p[3]);
            b_in.sv = (ss[65:64] != 2'b00) ? '1 : ss[63:0];
         end
         OP_AXIS: begin
            g = 42'(a_ff.ang);
            if (g >= HalfP) g = g - Per;
            else if (g < -HalfP) g = g + Per;
            if (g > Quarter) begin
               g = HalfP - g;
               b_in.cneg = 1'b1;
            end else if (g < -Quarter) begin
               g = -HalfP - g;
               b_in.cneg = 1'b1;
            end
            b_in.cz = 34'(g);
         end
         default: begin
            g = '0;
         end
      endcase
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            s = sat32(v[r][c]);
            b_in.rv[r][c] = s.val;
            b_in.rerr[r]  = b_in.rerr[r] | s.ovf;
         end
      end
   end

   // Stage C: angle in degrees to half angle in radians in Q30, CORDIC start vector.
   logic signed [50:0] zp;

   assign zp = $signed(b_ff.cz[26:0]) * PiOver360Q30;

   always_comb begin
      c_in = b_ff;
      if (b_ff.op == OP_AXIS) begin
         c_in.cz = 34'(zp >>> FRAC_BITS);
         c_in.cx = CordicGain;
         c_in.cy = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.vld <= 1'b0;
      end else if (ld_a) begin
         a_ff <= a_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.vld <= 1'b0;
         c_ff.vld <= 1'b0;
      end else if (en) begin
         b_ff <= b_in;
         c_ff <= c_in;
      end
   end

   assign q_out = c_ff;

endmodule

// ----- rtl/core/qau_iter_step.sv -----
// One square-root step and, when CORDIC_ON is set, one CORDIC rotation, as one pipeline stage.
module qau_iter_step #(
   parameter int STEP      = 0,
   parameter bit CORDIC_ON = 1'b1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  qau_pkg::pipe_type d_in,
   output qau_pkg::pipe_type q_out
);
   import qau_pkg::*;

   localparam logic [63:0]        SqBit = 64'd1 << (62 - 2 * STEP);
   localparam logic signed [33:0] Atan  = $signed({2'b00, AtanTab[STEP]});

   pipe_type    step_ff, step_in;
   logic [63:0] trial;

   assign trial = d_in.sr + SqBit;

   always_comb begin
      step_in = d_in;
      if (d_in.op == OP_NORM) begin
         if (d_in.sv >= trial) begin
            step_in.sv = d_in.sv - trial;
            step_in.sr = (d_in.sr >> 1) + SqBit;
         end else begin
            step_in.sr = d_in.sr >> 1;
         end
      end
      if (CORDIC_ON && d_in.op == OP_AXIS) begin
         if (!d_in.cz[33]) begin
            step_in.cx = d_in.cx - ($signed(d_in.cy) >>> STEP);
            step_in.cy = d_in.cy + ($signed(d_in.cx) >>> STEP);
            step_in.cz = d_in.cz - Atan;
         end else begin
            step_in.cx = d_in.cx + ($signed(d_in.cy) >>> STEP);
            step_in.cy = d_in.cy - ($signed(d_in.cx) >>> STEP);
            step_in.cz = d_in.cz + Atan;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.vld <= 1'b0;
      end else if (en) begin
         step_ff <= step_in;
      end
   end

   assign q_out = step_ff;

endmodule

// ----- rtl/core/qau_div_step.sv -----
// One restoring-division step for the four normalize quotients.
module qau_div_step #(
   parameter int BIT_POS = 16,
   parameter bit INIT    = 1'b0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  qau_pkg::pipe_type d_in,
   output qau_pkg::pipe_type q_out
);
   import qau_pkg::*;

   pipe_type    div_ff, div_in;
   logic [33:0] mag;
   logic [33:0] r;
   logic [31:0] aabs;

   assign mag = {2'b00, d_in.sr[31:0]};

   always_comb begin
      div_in = d_in;
      r      = '0;
      aabs   = '0;
      if (d_in.op == OP_NORM) begin
         for (int k = 0; k < 4; k++) begin
            aabs = d_in.a[k][31] ? 32'(-$signed(d_in.a[k])) : d_in.a[k];
            r    = INIT ? {2'b00, aabs} : d_in.rem[k];
            if (INIT) div_in.quo[k] = '0;
            if (r >= mag) begin
               r = r - mag;
               div_in.quo[k][BIT_POS] = 1'b1;
            end
            div_in.rem[k] = r << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.vld <= 1'b0;
      end else if (en) begin
         div_ff <= div_in;
      end
   end

   assign q_out = div_ff;

endmodule

// ----- rtl/core/qau_finish.sv -----
// Last stage and output register: normalize signs, axis-angle scaling and saturation.
module qau_finish #(
   parameter int FRAC_BITS = qau_pkg::FracBitsDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  qau_pkg::pipe_type d_in,
   output qau_pkg::pipe_type q_out
);
   import qau_pkg::*;

   pipe_type           fin_ff, fin_in;
   logic signed [33:0] c;
   logic signed [63:0] sp [3];
   sat_type            s;

   assign c = d_in.cneg ? -d_in.cx : d_in.cx;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sp[k] = $signed(d_in.a[k + 1]) * $signed(d_in.cy[31:0]);
      end
   end

   always_comb begin
      fin_in = d_in;
      s      = '0;
      case (d_in.op)
         OP_NORM: begin
            fin_in.rerr = '0;
            fin_in.rv   = '0;
            if (d_in.sr[31:0] == 32'd0) begin
               fin_in.rerr[0] = 1'b1;
            end else begin
               for (int k = 0; k < 4; k++) begin
                  fin_in.rv[0][k] = d_in.a[k][31] ? 32'(-$signed(d_in.quo[k])) : d_in.quo[k];
               end
            end
         end
         OP_AXIS: begin
            fin_in.rerr = '0;
            fin_in.rv   = '0;
            s = sat32(68'(c >>> (30 - FRAC_BITS)));
            fin_in.rv[0][0] = s.val;
            fin_in.rerr[0]  = s.ovf;
            for (int k = 0; k < 3; k++) begin
               s = sat32(68'(sp[k] >>> 30));
               fin_in.rv[0][k + 1] = s.val;
               fin_in.rerr[0]      = fin_in.rerr[0] | s.ovf;
            end
         end
         default: begin
            fin_in = d_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff.vld <= 1'b0;
      end else if (en) begin
         fin_ff <= fin_in;
      end
   end

   assign q_out = fin_ff;

endmodule

// ----- rtl/core/quaternion_arithmetic_unit.sv -----
// Top level of the fixed-point quaternion arithmetic unit.
//
//   Channel   Direction  Word                              Accepted when
//   req_*     in         operation, A, B, angle            req_tvalid && req_tready
//   rsp_*     out        one quaternion or one matrix row  rsp_tvalid && rsp_tready
//
// Stages: three front stages, 32 square-root stages (the CORDIC runs in the first
// ITERATIONS of them), FRAC_BITS + 1 divider stages and the output stage.
// A new word enters every cycle while the pipeline does not hold; multiply, normalize and
// axis-angle give one result word each, while a matrix holds the output register for four
// words, one per row, so a stream of matrix requests stalls while each matrix goes out.
// Reset is synchronous and clears the valid bits and the row counter only.
// When the output word is not taken the whole pipeline holds; the first stage still
// takes a word while it is empty, so input is accepted while a result waits.
module quaternion_arithmetic_unit #(
   parameter int FRAC_BITS  = qau_pkg::FracBitsDef,
   parameter int ITERATIONS = qau_pkg::IterDef
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z (32 bits each), angle_degrees (26 bits), zero pad
   input  logic [287:0] req_tdata,
   // operation
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // res0, res1, res2, res3 (32 bits each)
   output logic [127:0] rsp_tdata,
   output logic         rsp_tlast,
   // error
   output logic [0:0]   rsp_tuser
);
   import qau_pkg::*;

   localparam int          NumDiv = FRAC_BITS + 1;
   localparam logic [31:0] One    = 32'(longint'(1) << FRAC_BITS);

   req_type    req;
   pipe_type   it_q [0:32];
   pipe_type   dv_q [0:NumDiv];
   pipe_type   fin;
   logic       pipe_en;
   logic       a_vld;
   logic       last_row;
   logic [1:0] row_ff, row_in;
   logic [1:0] rsel;

   // Unpack the request word.
   always_comb begin
      req.op = op_type'(req_tuser);
      for (int k = 0; k < 4; k++) begin
         req.a[k] = req_tdata[32 * k +: 32];
         req.b[k] = req_tdata[128 + 32 * k +: 32];
      end
      req.ang = req_tdata[256 +: AngW];
   end

   // The pipeline moves when the output register is empty or hands over its final word.
   assign last_row = (fin.op != OP_MAT) || (row_ff == 2'd3);
   assign pipe_en  = !fin.vld || (rsp_tready && last_row);

   qau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .req_valid (req_tvalid),
      .req_in    (req),
      .in_ready  (req_tready),
      .a_vld     (a_vld),
      .q_out     (it_q[0])
   );

   // Square-root iterations; the CORDIC shares the same stages.
   for (genvar gs = 0; gs < 32; gs++) begin : g_iter
      qau_iter_step #(.STEP(gs), .CORDIC_ON(gs < ITERATIONS)) u_step (
         .clock (clock),
         .reset (reset),
         .en    (pipe_en),
         .d_in  (it_q[gs]),
         .q_out (it_q[gs + 1])
      );
   end

   assign dv_q[0] = it_q[32];

   // One quotient bit per stage, most significant first.
   for (genvar gd = 0; gd < NumDiv; gd++) begin : g_div
      qau_div_step #(.BIT_POS(FRAC_BITS - gd), .INIT(gd == 0)) u_div (
         .clock (clock),
         .reset (reset),
         .en    (pipe_en),
         .d_in  (dv_q[gd]),
         .q_out (dv_q[gd + 1])
      );
   end

   qau_finish #(.FRAC_BITS(FRAC_BITS)) u_finish (
      .clock (clock),
      .reset (reset),
      .en    (pipe_en),
      .d_in  (dv_q[NumDiv]),
      .q_out (fin)
   );

   // Row counter for matrix results; other operations stay on row zero.
   always_comb begin
      row_in = row_ff;
      if (fin.vld && rsp_tready) row_in = last_row ? 2'd0 : row_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= 2'd0;
      end else begin
         row_ff <= row_in;
      end
   end

   // The fourth matrix row is constant.
   assign rsel       = (row_ff == 2'd3) ? 2'd0 : row_ff;
   assign rsp_tvalid = fin.vld;
   assign rsp_tlast  = last_row;
   assign rsp_tdata  = (fin.op == OP_MAT && row_ff == 2'd3) ? {One, 96'd0} :
                       {fin.rv[rsel][3], fin.rv[rsel][2], fin.rv[rsel][1], fin.rv[rsel][0]};
   assign rsp_tuser  = (fin.op == OP_MAT && row_ff == 2'd3) ? 1'b0 : fin.rerr[rsel];

   // Only a matrix result ever leaves row zero.
   a_row_single : assert property (@(posedge clock) disable iff (reset)
      fin.vld && fin.op != OP_MAT |-> row_ff == 2'd0)
      else $error("row counter moved for a single-word result");

   // After the final word of an item goes out, the row counter starts over.
   a_row_wrap : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> row_ff == 2'd0)
      else $error("row counter did not restart after the final word");

   // Input is refused only when the first stage is full and the output is blocked.
   a_ready : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> a_vld && fin.vld)
      else $error("input refused without a stall");

endmodule

// ----- verif/tb_quaternion_arithmetic_unit.sv -----
// Self-checking testbench for the quaternion arithmetic unit.
module tb_quaternion_arithmetic_unit;
   import qau_pkg::*;

   localparam int FracBits = 16;
   localparam int Iters    = 24;
   localparam int Latency  = FracBits + 37;
   localparam int WatchdogLimit = 20000;
   localparam int NumRandom = 460;

   typedef struct {
      op_type            op;
      logic [31:0]       a [4];
      logic [31:0]       b [4];
      logic [AngW-1:0]   ang;
   } quat_req_type;

   typedef struct {
      logic [31:0] res [4];
      logic        last;
      logic        err;
   } quat_rsp_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [287:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic         rsp_tlast;
   logic [0:0]   rsp_tuser;

   quaternion_arithmetic_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // The clock runs with a 12-unit period and starts low.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   quat_req_type pending_words [$];
   quat_rsp_type expected_words [$];
   int  fail_count = 0;
   int  idle_cycles;
   bit  gen_done;
   bit  quiet_mode;      // no random idling on either side while set
   bit  hold_receiver;   // long receiver stall request
   bit  sender_pause;    // sender waits until all results are back
   int  hold_count;

   function automatic longint fix_mul(longint x, longint y);
      return (x * y) >>> FracBits;
   endfunction

   function automatic logic [31:0] clamp32(longint v, ref bit ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic void push_result(longint v [4], bit last, bit err);
      quat_rsp_type r;
      bit ovf;
      ovf = err;
      for (int j = 0; j < 4; j++) r.res[j] = clamp32(v[j], ovf);
      r.last = last;
      r.err  = ovf;
      expected_words.push_back(r);
   endfunction

   // Floor square root of an unsigned 64-bit value, bit by bit.
   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   // Sine and cosine of half the angle, both with 30 fraction bits.
   function automatic void half_sincos(longint ang, output longint s30, output longint c30);
      longint one, period, halfp, quarter, x, y, z, nx, atn;
      bit neg;
      one = longint'(1) << FracBits;
      period = 720 * one;
      halfp = 360 * one;
      quarter = 180 * one;
      x = 652032874;
      y = 0;
      neg = 1'b0;
      ang = ang % period;
      if (ang >= halfp) ang -= period;
      if (ang < -halfp) ang += period;
      if (ang > quarter) begin
         ang = halfp - ang;
         neg = 1'b1;
      end else if (ang < -quarter) begin
         ang = -halfp - ang;
         neg = 1'b1;
      end
      z = (ang * 64'sd9370165) >>> FracBits;
      for (int i = 0; i < Iters && i < 32; i++) begin
         atn = longint'(AtanTab[i]);
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= atn;
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += atn;
         end
         x = nx;
      end
      s30 = y;
      c30 = neg ? -x : x;
   endfunction

   // Works out every result word that one request causes.
   function automatic void predict_quat(quat_req_type q);
      longint a [4], b [4], v [4];
      longint one, s30, c30;
      longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
      longint unsigned sq, total, mag;
      one = longint'(1) << FracBits;
      for (int j = 0; j < 4; j++) begin
         a[j] = longint'(signed'(q.a[j]));
         b[j] = longint'(signed'(q.b[j]));
      end
      case (q.op)
         OP_MUL: begin
            v[0] = fix_mul(a[0], b[0]) - fix_mul(a[1], b[1]) - fix_mul(a[2], b[2])
                   - fix_mul(a[3], b[3]);
            v[1] = fix_mul(a[0], b[1]) + fix_mul(a[1], b[0]) + fix_mul(a[2], b[3])
                   - fix_mul(a[3], b[2]);
            v[2] = fix_mul(a[0], b[2]) + fix_mul(a[2], b[0]) + fix_mul(a[3], b[1])
                   - fix_mul(a[1], b[3]);
            v[3] = fix_mul(a[0], b[3]) + fix_mul(a[3], b[0]) + fix_mul(a[1], b[2])
                   - fix_mul(a[2], b[1]);
            push_result(v, 1'b1, 1'b0);
         end
         OP_NORM: begin
            total = 0;
            for (int j = 0; j < 4; j++) begin
               sq = longint'(a[j] * a[j]);
               total = (total > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                               : total + sq;
            end
            mag = floor_sqrt(total);
            if (mag == 0) begin
               for (int j = 0; j < 4; j++) v[j] = 0;
               push_result(v, 1'b1, 1'b1);
            end else begin
               // Signed division truncates toward zero; mag is below 2^32.
               for (int j = 0; j < 4; j++) v[j] = (a[j] * one) / longint'(mag);
               push_result(v, 1'b1, 1'b0);
            end
         end
         OP_AXIS: begin
            half_sincos(longint'(signed'(q.ang)), s30, c30);
            v[0] = c30 >>> (30 - FracBits);
            v[1] = (a[1] * s30) >>> 30;
            v[2] = (a[2] * s30) >>> 30;
            v[3] = (a[3] * s30) >>> 30;
            push_result(v, 1'b1, 1'b0);
         end
         default: begin
            xx = fix_mul(a[1], a[1]);
            yy = fix_mul(a[2], a[2]);
            zz = fix_mul(a[3], a[3]);
            xy = fix_mul(a[1], a[2]);
            xz = fix_mul(a[1], a[3]);
            yz = fix_mul(a[2], a[3]);
            wx = fix_mul(a[0], a[1]);
            wy = fix_mul(a[0], a[2]);
            wz = fix_mul(a[0], a[3]);
            v = '{one - 2 * (yy + zz), 2 * (xy + wz), 2 * (xz - wy), 0};
            push_result(v, 1'b0, 1'b0);
            v = '{2 * (xy - wz), one - 2 * (xx + zz), 2 * (yz + wx), 0};
            push_result(v, 1'b0, 1'b0);
            v = '{2 * (xz + wy), 2 * (yz - wx), one - 2 * (xx + yy), 0};
            push_result(v, 1'b0, 1'b0);
            v = '{0, 0, 0, one};
            push_result(v, 1'b1, 1'b0);
         end
      endcase
   endfunction

   // Random 32-bit operand, biased toward extremes and small Q16.16 values.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return 32'(signed'($urandom_range(0, 8 * 65536)) - 4 * 65536);
         default: return 32'(signed'($urandom_range(0, 2 * 65536)) - 65536);
      endcase
   endfunction

   function automatic quat_req_type make_word(op_type op, logic [31:0] aw, logic [31:0] ax,
                                              logic [31:0] ay, logic [31:0] az,
                                              logic [AngW-1:0] ang);
      quat_req_type q;
      q.op = op;
      q.a = '{aw, ax, ay, az};
      for (int j = 0; j < 4; j++) q.b[j] = pick_operand();
      q.ang = ang;
      return q;
   endfunction

   // Stimulus: a directed set of corner cases, then random words.
   initial begin
      quat_req_type q;
      logic [31:0] one_q, max_q, min_q;
      quiet_mode = 1'b0;
      hold_receiver = 1'b0;
      sender_pause = 1'b0;
      gen_done = 1'b0;
      one_q = 32'h0001_0000;
      max_q = 32'h7FFF_FFFF;
      min_q = 32'h8000_0000;

      // Multiply: identity, all maximum, all minimum (saturates), mixed.
      q = make_word(OP_MUL, one_q, 0, 0, 0, 0);
      q.b = '{one_q, one_q, one_q, one_q};
      pending_words.push_back(q);
      q = make_word(OP_MUL, max_q, max_q, max_q, max_q, 0);
      q.b = '{max_q, max_q, max_q, max_q};
      pending_words.push_back(q);
      q = make_word(OP_MUL, min_q, min_q, min_q, min_q, 0);
      q.b = '{min_q, min_q, min_q, min_q};
      pending_words.push_back(q);
      q = make_word(OP_MUL, min_q, max_q, min_q, max_q, 0);
      q.b = '{max_q, min_q, max_q, min_q};
      pending_words.push_back(q);
      // Normalize: zero magnitude, extremes whose sum saturates, mixed extremes, tiny value, all ones.
      pending_words.push_back(make_word(OP_NORM, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(OP_NORM, min_q, min_q, min_q, min_q, 0));
      pending_words.push_back(make_word(OP_NORM, max_q, min_q, max_q, min_q, 0));
      pending_words.push_back(make_word(OP_NORM, 0, 0, 0, 32'd1, 0));
      pending_words.push_back(make_word(OP_NORM, one_q, one_q, one_q, one_q, 0));
      // Axis-angle: zero, plus and minus 360, fold boundaries, full 26-bit range.
      pending_words.push_back(make_word(OP_AXIS, 0, one_q, 0, 0, 0));
      pending_words.push_back(make_word(OP_AXIS, 0, max_q, min_q, max_q, 26'sd23592960));
      pending_words.push_back(make_word(OP_AXIS, 0, min_q, max_q, min_q, -26'sd23592960));
      pending_words.push_back(make_word(OP_AXIS, 0, 0, one_q, 0, 26'sd11796480));
      pending_words.push_back(make_word(OP_AXIS, 0, 0, 0, one_q, -26'sd11796480));
      pending_words.push_back(make_word(OP_AXIS, 0, one_q, one_q, one_q, 26'h1FF_FFFF));
      pending_words.push_back(make_word(OP_AXIS, 0, one_q, one_q, one_q, 26'h200_0000));
      pending_words.push_back(make_word(OP_AXIS, 0, one_q, 0, 0, 26'sd11796481));
      // Matrix: identity, extremes that saturate, and zero.
      pending_words.push_back(make_word(OP_MAT, one_q, 0, 0, 0, 0));
      pending_words.push_back(make_word(OP_MAT, max_q, max_q, max_q, max_q, 0));
      pending_words.push_back(make_word(OP_MAT, min_q, min_q, min_q, min_q, 0));
      pending_words.push_back(make_word(OP_MAT, 0, 0, 0, 0, 0));

      // The sender holds back until every directed result has come.
      wait (pending_words.size() == 0);
      sender_pause = 1'b1;
      wait (expected_words.size() == 0);
      @(posedge clock);
      sender_pause = 1'b0;

      for (int n = 0; n < NumRandom; n++) begin
         q = make_word(op_type'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                       pick_operand(), pick_operand(),
                       AngW'(signed'($urandom_range(0, 2 * 23592960)) - 23592960));
         if ($urandom_range(0, 9) == 0) q.ang = AngW'($urandom());
         pending_words.push_back(q);
         if (n == 100) begin
            // A long receiver stall while the sender keeps offering words.
            wait (pending_words.size() == 0);
            hold_receiver = 1'b1;
         end
         if (n == 250) begin
            wait (pending_words.size() == 0);
            quiet_mode = 1'b1;
         end
         if (n == 350) begin
            wait (pending_words.size() == 0);
            quiet_mode = 1'b0;
         end
      end
      gen_done = 1'b1;
   end

   // Driver: offers the oldest pending word, with random gaps.
   always @(posedge clock) begin
      quat_req_type q;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) void'(pending_words.pop_front());
         if (pending_words.size() > (req_tvalid ? 0 : 0) && !sender_pause
             && (quiet_mode || $urandom_range(0, 99) >= 35)) begin
            q = pending_words[0];
            predict_quat(q);
            req_tvalid <= 1'b1;
            req_tuser  <= q.op;
            req_tdata  <= {6'd0, q.ang, q.b[3], q.b[2], q.b[1], q.b[0],
                           q.a[3], q.a[2], q.a[1], q.a[0]};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver ready: random stalls, plus one long hold-off of its own.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_count <= 0;
      end else if (hold_receiver && hold_count < 400) begin
         hold_count <= hold_count + 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet_mode || ($urandom_range(0, 99) >= 35);
      end
   end

   // Monitor: compares each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      quat_rsp_type e;
      logic [31:0] got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word %h", rsp_tdata);
            fail_count++;
         end else begin
            e = expected_words.pop_front();
            for (int j = 0; j < 4; j++) begin
               got = rsp_tdata[32 * j +: 32];
               if (got !== e.res[j]) begin
                  $error("res%0d: expected %h, actual %h", j, e.res[j], got);
                  fail_count++;
               end
            end
            if (rsp_tlast !== e.last) begin
               $error("last: expected %b, actual %b", e.last, rsp_tlast);
               fail_count++;
            end
            if (rsp_tuser[0] !== e.err) begin
               $error("error: expected %b, actual %b", e.err, rsp_tuser[0]);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("quaternion_arithmetic_unit verification failed");
            $finish;
         end
      end
   end

   // Reset, then wait for the stimulus to drain and the pipeline to settle.
   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (gen_done && pending_words.size() == 0 && !req_tvalid);
      wait (expected_words.size() == 0);
      repeat (Latency + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("quaternion_arithmetic_unit verification clean");
      end else begin
         $display("quaternion_arithmetic_unit verification failed");
      end
      $finish;
   end

endmodule
